### src/rbd_pkg.sv
`timescale 1ns / 1ps

package rbd_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF      = 32;
    localparam int ELEM_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int OP_W  = 3;
    localparam int POS_W = 5;
    localparam int ST_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK       = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic write_en;
        logic read_en;
    } rbd_ctrl_t;

endpackage

### src/rbd_cell.sv
`timescale 1ns / 1ps

module rbd_cell import rbd_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int IDX        = 0
) (
    input  logic                       aclk,
    input  rbd_ctrl_t                  ctrl,
    input  logic [$clog2(DEPTH)-1:0]   wr_idx,
    input  logic [$clog2(DEPTH)-1:0]   rd_idx,
    input  logic [ELEM_WIDTH-1:0]      wr_data,
    input  logic [ELEM_WIDTH-1:0]      left_q,
    input  logic [ELEM_WIDTH-1:0]      right_q,
    output logic [ELEM_WIDTH-1:0]      q,
    output logic [ELEM_WIDTH-1:0]      rd_q
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;

    // A direct write wins over a shift: push front writes cell 0 while the rest move right
    always_comb begin
        priority if (ctrl.write_en && (wr_idx == MY_IDX)) begin
            data_next = wr_data;
        end else if (ctrl.shift_right) begin
            data_next = left_q;
        end else if (ctrl.shift_left) begin
            data_next = right_q;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q    = data_reg;
    assign rd_q = (ctrl.read_en && (rd_idx == MY_IDX)) ? data_reg : '0;

endmodule

### src/ring_buffer_deque.sv
`timescale 1ns / 1ps
// A result word is registered and valid on m_* in the cycle after its input word is accepted.
// Throughput: one word per cycle; the output register frees s_ready as soon as
//   m_ready takes the held result, so the cell chain updates in the accept cycle.
// Reset (aresetn low, synchronous): fill count and output valid clear; cell
//   contents are not reset and only entries below the fill count are ever read.

module ring_buffer_deque import rbd_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [OP_W-1:0]              s_operation,
    input  logic [ELEM_WIDTH-1:0]        s_element,
    input  logic [POS_W-1:0]             s_position,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ELEM_WIDTH-1:0]        m_data,
    output logic [ST_W-1:0]              m_status,
    output logic [$clog2(DEPTH+1)-1:0]   m_fill
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // The deque lives in a row of cells: cell 0 always holds the front entry,
    // cell count-1 the back. Push/pop at the front shift the whole row by one.
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      count_dec;

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [ELEM_WIDTH-1:0] m_data_reg;
    logic [ELEM_WIDTH-1:0] m_data_next;
    status_t               m_status_reg;
    status_t               m_status_next;
    logic [CNT_W-1:0]      m_fill_reg;

    logic                  s_accept;
    op_t                   op;
    logic                  is_full;
    logic                  is_empty;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;

    rbd_ctrl_t             ctrl;
    logic [IDX_W-1:0]      wr_idx;
    logic [IDX_W-1:0]      rd_idx;
    logic [ELEM_WIDTH-1:0] rd_bus;

    logic [ELEM_WIDTH-1:0] cell_q  [DEPTH];
    logic [ELEM_WIDTH-1:0] cell_rd [DEPTH];

    // Take a new word whenever the output register is empty or being drained
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign op        = op_t'(s_operation);
    assign is_full   = (count_reg == FULL_CNT);
    assign is_empty  = (count_reg == '0);
    assign count_dec = count_reg - CNT_W'(1);
    assign pos_ext   = CMP_W'(s_position);
    assign cnt_ext   = CMP_W'(count_reg);

    // Decode the operation into a chain command; nothing moves without an accept
    always_comb begin
        ctrl          = '0;
        wr_idx        = '0;
        rd_idx        = '0;
        count_next    = count_reg;
        m_data_next   = '0;
        m_status_next = ST_OK;
        if (s_accept) begin
            unique case (op)
                OP_PUSH_FRONT: begin
                    if (is_full) begin
                        m_status_next = ST_FULL;
                    end else begin
                        // shift everything back one cell, drop the new word into cell 0
                        ctrl.shift_right = 1'b1;
                        ctrl.write_en    = 1'b1;
                        count_next       = count_reg + CNT_W'(1);
                        m_data_next      = s_element;
                    end
                end
                OP_PUSH_BACK: begin
                    if (is_full) begin
                        m_status_next = ST_FULL;
                    end else begin
                        ctrl.write_en = 1'b1;
                        wr_idx        = count_reg[IDX_W-1:0];
                        count_next    = count_reg + CNT_W'(1);
                        m_data_next   = s_element;
                    end
                end
                OP_POP_FRONT: begin
                    if (is_empty) begin
                        m_status_next = ST_EMPTY;
                    end else begin
                        // read cell 0, then advance the row toward the front
                        ctrl.read_en    = 1'b1;
                        ctrl.shift_left = 1'b1;
                        count_next      = count_dec;
                        m_data_next     = rd_bus;
                    end
                end
                OP_POP_BACK: begin
                    if (is_empty) begin
                        m_status_next = ST_EMPTY;
                    end else begin
                        ctrl.read_en = 1'b1;
                        rd_idx       = count_dec[IDX_W-1:0];
                        count_next   = count_dec;
                        m_data_next  = rd_bus;
                    end
                end
                OP_PEEK: begin
                    if (pos_ext >= cnt_ext) begin
                        m_status_next = ST_EMPTY;
                    end else begin
                        ctrl.read_en = 1'b1;
                        rd_idx       = pos_ext[IDX_W-1:0];
                        m_data_next  = rd_bus;
                    end
                end
                default: begin
                    // unused opcodes: report empty, touch nothing
                    m_status_next = ST_EMPTY;
                end
            endcase
        end
    end

    // Output register: load on accept, drop once the consumer takes it
    always_comb begin
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload holds while a result waits
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg   <= m_data_next;
            m_status_reg <= m_status_next;
            m_fill_reg   <= count_next;
        end
    end

    // Cell chain; the ends see zero beyond the row
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ELEM_WIDTH-1:0] left_q;
        logic [ELEM_WIDTH-1:0] right_q;

        if (i == 0) begin : g_first
            assign left_q = '0;
        end else begin : g_mid_l
            assign left_q = cell_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_q = '0;
        end else begin : g_mid_r
            assign right_q = cell_q[i+1];
        end

        rbd_cell #(
            .DEPTH      (DEPTH),
            .ELEM_WIDTH (ELEM_WIDTH),
            .IDX        (i)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .wr_idx  (wr_idx),
            .rd_idx  (rd_idx),
            .wr_data (s_element),
            .left_q  (left_q),
            .right_q (right_q),
            .q       (cell_q[i]),
            .rd_q    (cell_rd[i])
        );
    end

    // At most one cell drives a nonzero read word, so OR the row together
    always_comb begin
        rd_bus = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_bus = rd_bus | cell_rd[i];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;
    assign m_fill   = m_fill_reg;

    // Fill count never runs past the row length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("fill count beyond depth");

    // Fill count moves only on an accepted word
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(count_reg))
        else $error("fill count changed without an accepted word");

    // A refused push reports a full row
    a_full_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_FULL)) |-> (m_fill_reg == FULL_CNT))
        else $error("full status with room left");

    // Empty or out-of-range results carry zero data
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_EMPTY)) |-> (m_data_reg == '0))
        else $error("empty status with nonzero data");

endmodule
